[src/ll1_table_driven_parser_assert.svh]
// assertion helpers used by the parser engine
`ifndef LL1_TABLE_DRIVEN_PARSER_ASSERT_SVH
`define LL1_TABLE_DRIVEN_PARSER_ASSERT_SVH

// same-cycle implication
`define LLP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("llp check failed");

// next-cycle implication
`define LLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("llp check failed");

`endif

[src/llp_pkg.sv]
`default_nettype none
package llp_pkg;

   // input opcodes
   localparam logic [2:0] OP_CELL   = 3'd0;
   localparam logic [2:0] OP_BODY   = 3'd1;
   localparam logic [2:0] OP_FOLLOW = 3'd2;
   localparam logic [2:0] OP_START  = 3'd3;
   localparam logic [2:0] OP_TOKEN  = 3'd4;

   // classified command kinds
   localparam logic [2:0] CMD_CELL   = 3'd0;
   localparam logic [2:0] CMD_BODY   = 3'd1;
   localparam logic [2:0] CMD_FOLLOW = 3'd2;
   localparam logic [2:0] CMD_START  = 3'd3;
   localparam logic [2:0] CMD_TOKEN  = 3'd4;
   localparam logic [2:0] CMD_IGNORE = 3'd5;

   // event kinds
   localparam logic [3:0] EV_EXPAND   = 4'd0;
   localparam logic [3:0] EV_MATCH    = 4'd1;
   localparam logic [3:0] EV_EPSILON  = 4'd2;
   localparam logic [3:0] EV_NO_RULE  = 4'd3;
   localparam logic [3:0] EV_MISMATCH = 4'd4;
   localparam logic [3:0] EV_SKIP     = 4'd5;
   localparam logic [3:0] EV_ACCEPT   = 4'd6;
   localparam logic [3:0] EV_REJECT   = 4'd7;
   localparam logic [3:0] EV_OVERFLOW = 4'd8;
   localparam logic [3:0] EV_STEP_LIM = 4'd9;
   localparam logic [3:0] EV_IGNORED  = 4'd10;

   // parse modes
   localparam logic [1:0] MODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_PARSING = 2'd1;
   localparam logic [1:0] MODE_RECOVER = 2'd2;
   localparam logic [1:0] MODE_DONE    = 2'd3;

   // register indexes
   localparam logic [1:0] REG_START     = 2'd0;
   localparam logic [1:0] REG_FIRST_NT  = 2'd1;
   localparam logic [1:0] REG_END_MARK  = 2'd2;
   localparam logic [1:0] REG_EPSILON   = 2'd3;

   localparam logic [7:0] STACK_DEPTH = 8'd64;
   localparam logic [6:0] STEP_CAP    = 7'd63;
   localparam logic [3:0] MAX_BODY    = 4'd8;

   typedef struct packed {
      logic [2:0] kind;
      logic [5:0] row_symbol;
      logic [5:0] column_symbol;
      logic [6:0] production_index;
      logic [2:0] body_position;
      logic [5:0] body_symbol;
      logic [3:0] body_length;
      logic       entry_valid;
      logic [5:0] token_type;
      logic       token_is_end;
   } cmd_type;

   typedef struct packed {
      logic [5:0] start_symbol;
      logic [5:0] first_nonterminal;
      logic [5:0] end_marker_code;
      logic [5:0] epsilon_code;
   } cfg_type;

endpackage
`default_nettype wire

[src/llp_front.sv]
`default_nettype none
module llp_front
   import llp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        hold,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // row, column, production, position, body symbol, body length, valid, token
   input  wire logic [39:0] req_tdata,
   // opcode
   input  wire logic [2:0]  req_tuser,
   input  wire logic        req_tlast,
   output cmd_type          cmd,
   output logic             cmd_valid,
   input  wire logic        cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       push;

   always_comb begin
      dec.row_symbol       = req_tdata[5:0];
      dec.column_symbol    = req_tdata[11:6];
      dec.production_index = req_tdata[18:12];
      dec.body_position    = req_tdata[21:19];
      dec.body_symbol      = req_tdata[27:22];
      dec.body_length      = (req_tdata[31:28] > MAX_BODY) ? MAX_BODY : req_tdata[31:28];
      dec.entry_valid      = req_tdata[32];
      dec.token_type       = req_tdata[38:33];
      dec.token_is_end     = req_tlast;
      unique case (req_tuser)
         OP_CELL:   dec.kind = CMD_CELL;
         OP_BODY:   dec.kind = CMD_BODY;
         OP_FOLLOW: dec.kind = CMD_FOLLOW;
         OP_START:  dec.kind = CMD_START;
         OP_TOKEN:  dec.kind = CMD_TOKEN;
         default:   dec.kind = CMD_IGNORE;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2) && !hold;
   assign push       = req_tvalid && req_tready;
   assign cmd        = q_ff[rd_ff];
   assign cmd_valid  = cnt_ff != 2'd0;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = cmd_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= dec;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

[src/llp_engine.sv]
`default_nettype none
`include "ll1_table_driven_parser_assert.svh"
module llp_engine
   import llp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  cmd_type          cmd,
   input  wire logic        cmd_valid,
   output logic             cmd_pop,
   input  cfg_type          cfg,
   output logic             clearing,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // symbol, production, token
   output logic [23:0]      rsp_tdata,
   // event kind
   output logic [3:0]       rsp_tuser,
   output logic             rsp_tlast
);

   localparam logic [3:0] ST_CLEAR   = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_FETCH   = 4'd2;
   localparam logic [3:0] ST_EVAL    = 4'd3;
   localparam logic [3:0] ST_LEN     = 4'd4;
   localparam logic [3:0] ST_PUSHRD  = 4'd5;
   localparam logic [3:0] ST_PUSHWR  = 4'd6;
   localparam logic [3:0] ST_POPWAIT = 4'd7;

   // memories
   logic [7:0] tbl_mem [2048];
   logic       fol_mem [4096];
   logic [5:0] body_mem [1024];
   logic [3:0] len_mem [128];
   logic [5:0] stk_mem [64];

   logic        tbl_we, fol_we, body_we, len_we, stk_we;
   logic [10:0] tbl_wa, tbl_ra;
   logic [7:0]  tbl_wd, tbl_q;
   logic [11:0] fol_wa, fol_ra;
   logic        fol_wd, fol_q;
   logic [9:0]  body_wa, body_ra;
   logic [5:0]  body_wd, body_q;
   logic [6:0]  len_wa, len_ra;
   logic [3:0]  len_wd, len_q;
   logic [5:0]  stk_wa, stk_ra, stk_wd, stk_q;

   logic [3:0]  state_ff, state_in;
   logic [6:0]  sp_ff, sp_in;
   logic [5:0]  top_ff, top_in;
   logic [1:0]  mode_ff, mode_in;
   logic [5:0]  rec_ff, rec_in;
   logic [6:0]  n_ff, n_in;
   logic [5:0]  tok_ff, tok_in;
   logic        end_ff, end_in;
   logic [6:0]  prod_ff, prod_in;
   logic [2:0]  k_ff, k_in;
   logic [5:0]  wp_ff, wp_in;
   logic        ret_idle_ff, ret_idle_in;
   logic [11:0] clr_ff, clr_in;

   logic        ov_ff, ok_last_ff;
   logic [3:0]  okind_ff;
   logic [5:0]  osym_ff, otok_ff;
   logic [6:0]  oprod_ff;

   logic        emit, e_last, ofree, at_cap;
   logic [3:0]  e_kind;
   logic [5:0]  e_sym, e_tok, top_eff;
   logic [6:0]  e_prod;
   logic [3:0]  eff_len;
   logic [7:0]  new_sp;

   assign ofree   = !ov_ff || rsp_tready;
   assign at_cap  = n_ff >= STEP_CAP;
   assign top_eff = (sp_ff != 7'd0) ? top_ff : cfg.end_marker_code;
   assign eff_len = (len_q == 4'd1 && body_q == cfg.epsilon_code) ? 4'd0 : len_q;
   assign new_sp  = {1'b0, sp_ff} - 8'd1 + {4'd0, eff_len};
   assign clearing = state_ff == ST_CLEAR;

   // read addresses follow the current stack top and recovery symbol
   assign tbl_ra  = {top_ff[4:0], tok_ff};
   assign fol_ra  = {rec_ff, tok_ff};
   assign len_ra  = tbl_q[6:0];
   assign body_ra = (state_ff == ST_PUSHRD) ? {prod_ff, k_ff} : {tbl_q[6:0], 3'd0};
   assign stk_ra  = 6'(sp_ff - 7'd2);

   always_comb begin
      state_in    = state_ff;
      sp_in       = sp_ff;
      top_in      = top_ff;
      mode_in     = mode_ff;
      rec_in      = rec_ff;
      n_in        = n_ff;
      tok_in      = tok_ff;
      end_in      = end_ff;
      prod_in     = prod_ff;
      k_in        = k_ff;
      wp_in       = wp_ff;
      ret_idle_in = ret_idle_ff;
      clr_in      = clr_ff;
      cmd_pop     = 1'b0;
      tbl_we = 1'b0; tbl_wa = {cmd.row_symbol[4:0], cmd.column_symbol};
      tbl_wd = {cmd.entry_valid, cmd.production_index};
      fol_we = 1'b0; fol_wa = {cmd.row_symbol, cmd.column_symbol};
      fol_wd = cmd.entry_valid;
      body_we = 1'b0; body_wa = {cmd.production_index, cmd.body_position};
      body_wd = cmd.body_symbol;
      len_we = 1'b0; len_wa = cmd.production_index; len_wd = cmd.body_length;
      stk_we = 1'b0; stk_wa = wp_ff; stk_wd = body_q;
      emit = 1'b0; e_kind = EV_IGNORED; e_sym = 6'd0; e_prod = 7'd0;
      e_tok = tok_ff; e_last = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            tbl_we = 1'b1; tbl_wa = clr_ff[10:0]; tbl_wd = 8'd0;
            fol_we = 1'b1; fol_wa = clr_ff; fol_wd = 1'b0;
            clr_in = clr_ff + 12'd1;
            if (clr_ff == 12'hfff) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd.kind)
                  CMD_CELL: begin
                     tbl_we = 1'b1; cmd_pop = 1'b1;
                  end
                  CMD_BODY: begin
                     body_we = 1'b1; len_we = 1'b1; cmd_pop = 1'b1;
                  end
                  CMD_FOLLOW: begin
                     fol_we = 1'b1; cmd_pop = 1'b1;
                  end
                  CMD_START: begin
                     // start symbol lives in the top register, marker in memory
                     stk_we = 1'b1; stk_wa = 6'd0; stk_wd = cfg.end_marker_code;
                     sp_in = 7'd2; top_in = cfg.start_symbol;
                     mode_in = MODE_PARSING; rec_in = 6'd0; cmd_pop = 1'b1;
                  end
                  CMD_TOKEN: begin
                     if (mode_ff == MODE_PARSING || mode_ff == MODE_RECOVER) begin
                        tok_in = cmd.token_type; end_in = cmd.token_is_end;
                        n_in = 7'd0; cmd_pop = 1'b1; state_in = ST_FETCH;
                     end else if (ofree) begin
                        emit = 1'b1; e_tok = cmd.token_type; e_last = 1'b1;
                        cmd_pop = 1'b1;
                     end
                  end
                  default: begin
                     if (ofree) begin
                        emit = 1'b1; e_tok = cmd.token_type; e_last = 1'b1;
                        cmd_pop = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_FETCH: state_in = ST_EVAL;
         ST_EVAL: begin
            if (mode_ff == MODE_RECOVER) begin
               if (end_ff || fol_q) begin
                  mode_in = MODE_PARSING;
                  if (sp_ff != 7'd0 && top_ff == rec_ff) begin
                     sp_in = sp_ff - 7'd1; ret_idle_in = 1'b0; state_in = ST_POPWAIT;
                  end else begin
                     state_in = ST_FETCH;
                  end
               end else if (ofree) begin
                  emit = 1'b1; e_sym = rec_ff; e_last = 1'b1;
                  e_kind = at_cap ? EV_STEP_LIM : EV_SKIP;
                  if (at_cap) mode_in = MODE_DONE;
                  state_in = ST_IDLE;
               end
            end else if (ofree) begin
               emit = 1'b1; e_sym = top_eff;
               priority if (at_cap) begin
                  e_kind = EV_STEP_LIM; e_last = 1'b1;
                  mode_in = MODE_DONE; state_in = ST_IDLE;
               end else if (top_eff == cfg.end_marker_code || sp_ff == 7'd0) begin
                  e_kind = end_ff ? EV_ACCEPT : EV_REJECT; e_last = 1'b1;
                  mode_in = MODE_DONE; state_in = ST_IDLE;
               end else if (top_ff == cfg.epsilon_code) begin
                  e_kind = EV_EPSILON;
                  sp_in = sp_ff - 7'd1; ret_idle_in = 1'b0; state_in = ST_POPWAIT;
               end else if (top_ff >= cfg.first_nonterminal) begin
                  if (tbl_q[7]) begin
                     // expand event goes out once the body length is known
                     emit = 1'b0; prod_in = tbl_q[6:0]; state_in = ST_LEN;
                  end else begin
                     e_kind = EV_NO_RULE; rec_in = top_ff;
                     mode_in = MODE_RECOVER; state_in = ST_FETCH;
                  end
               end else if (top_ff == tok_ff) begin
                  e_kind = EV_MATCH; e_last = 1'b1;
                  sp_in = sp_ff - 7'd1; ret_idle_in = 1'b1; state_in = ST_POPWAIT;
               end else begin
                  e_kind = EV_MISMATCH; rec_in = top_ff;
                  mode_in = MODE_RECOVER; state_in = ST_FETCH;
               end
            end
         end
         ST_LEN: begin
            if (ofree) begin
               emit = 1'b1; e_sym = top_ff; e_prod = prod_ff;
               if (new_sp > STACK_DEPTH) begin
                  e_kind = EV_OVERFLOW; e_last = 1'b1;
                  mode_in = MODE_DONE; state_in = ST_IDLE;
               end else begin
                  e_kind = EV_EXPAND;
                  sp_in = new_sp[6:0];
                  if (eff_len == 4'd0) begin
                     ret_idle_in = 1'b0; state_in = ST_POPWAIT;
                  end else begin
                     // first body symbol becomes the new top, the rest go below it
                     top_in = body_q;
                     wp_in  = 6'(sp_ff - 7'd1);
                     k_in   = 3'(eff_len - 4'd1);
                     state_in = (eff_len == 4'd1) ? ST_FETCH : ST_PUSHRD;
                  end
               end
            end
         end
         ST_PUSHRD: state_in = ST_PUSHWR;
         ST_PUSHWR: begin
            stk_we = 1'b1;
            wp_in = wp_ff + 6'd1;
            k_in  = k_ff - 3'd1;
            state_in = (k_ff == 3'd1) ? ST_FETCH : ST_PUSHRD;
         end
         ST_POPWAIT: begin
            top_in = stk_q;
            state_in = ret_idle_ff ? ST_IDLE : ST_FETCH;
         end
         default: state_in = ST_IDLE;
      endcase
      if (emit && state_ff != ST_IDLE) n_in = n_ff + 7'd1;
   end

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_mem[tbl_wa] <= tbl_wd;
      tbl_q <= tbl_mem[tbl_ra];
   end

   always_ff @(posedge clock) begin
      if (fol_we) fol_mem[fol_wa] <= fol_wd;
      fol_q <= fol_mem[fol_ra];
   end

   always_ff @(posedge clock) begin
      if (body_we) body_mem[body_wa] <= body_wd;
      body_q <= body_mem[body_ra];
   end

   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_wa] <= len_wd;
      len_q <= len_mem[len_ra];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      stk_q <= stk_mem[stk_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         sp_ff       <= 7'd0;
         mode_ff     <= MODE_IDLE;
         rec_ff      <= 6'd0;
         n_ff        <= 7'd0;
         ret_idle_ff <= 1'b0;
         clr_ff      <= 12'd0;
         ov_ff       <= 1'b0;
      end else begin
         state_ff    <= state_in;
         sp_ff       <= sp_in;
         mode_ff     <= mode_in;
         rec_ff      <= rec_in;
         n_ff        <= n_in;
         ret_idle_ff <= ret_idle_in;
         clr_ff      <= clr_in;
         if (emit) ov_ff <= 1'b1;
         else if (rsp_tready) ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      top_ff  <= top_in;
      tok_ff  <= tok_in;
      end_ff  <= end_in;
      prod_ff <= prod_in;
      k_ff    <= k_in;
      wp_ff   <= wp_in;
      if (emit) begin
         okind_ff   <= e_kind;
         osym_ff    <= e_sym;
         oprod_ff   <= e_prod;
         otok_ff    <= e_tok;
         ok_last_ff <= e_last;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tdata  = {5'd0, otok_ff, oprod_ff, osym_ff};
   assign rsp_tlast  = ok_last_ff;

   `LLP_ASSERT_NOW(a_stack_bound, clock, reset, 1'b1, {1'b0, sp_ff} <= STACK_DEPTH)
   `LLP_ASSERT_NOW(a_step_bound, clock, reset, 1'b1, n_ff <= 7'd64)
   `LLP_ASSERT_NOW(a_quiet_clear, clock, reset, state_ff == ST_CLEAR, !ov_ff && !cmd_pop)
   `LLP_ASSERT_NEXT(a_end_is_last, clock, reset,
      emit && (e_kind == EV_ACCEPT || e_kind == EV_REJECT), rsp_tlast && mode_ff == MODE_DONE)

endmodule
`default_nettype wire

[src/ll1_table_driven_parser.sv]
// channel   | direction | handshake             | payload
// req       | in        | req_tvalid/tready     | tdata fields, tuser opcode, tlast end
// rsp       | out       | rsp_tvalid/tready     | tdata sym/prod/token, tuser kind, tlast
// csr       | in        | psel/penable/pready   | four 6-bit registers
//
// after reset a clearing pass over all 4096 follow-bit addresses wipes the table and follow
// bits; req_tready stays low meanwhile. load and start words are taken in the idle state;
// a token steps through fetch and evaluate states, with a length state for each expansion,
// a read and a write state per further body symbol and a pop-wait state after a match or
// pop, as the table, body and stack memories are read through registers.
// a two-word queue parts the front from the engine and the output register holds one
// event, so the front keeps taking words, until its queue is full, while an event waits on rsp_tready.
`default_nettype none
module ll1_table_driven_parser
   import llp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // row[5:0] col[11:6] prod[18:12] pos[21:19] bsym[27:22] blen[31:28] valid[32] tok[38:33]
   input  wire logic [39:0] req_tdata,
   // opcode
   input  wire logic [2:0]  req_tuser,
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // symbol[5:0] production[12:6] token[18:13]
   output logic [23:0]      rsp_tdata,
   // event kind
   output logic [3:0]       rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   logic       cmd_valid, cmd_pop, clearing, wr;
   logic [5:0] rd_val;

   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_symbol      <= 6'd32;
         cfg_ff.first_nonterminal <= 6'd32;
         cfg_ff.end_marker_code   <= 6'd0;
         cfg_ff.epsilon_code      <= 6'd1;
      end else if (wr) begin
         unique case (csr_paddr[3:2])
            REG_START:    cfg_ff.start_symbol      <= csr_pwdata[5:0];
            REG_FIRST_NT: cfg_ff.first_nonterminal <= csr_pwdata[5:0];
            REG_END_MARK: cfg_ff.end_marker_code   <= csr_pwdata[5:0];
            REG_EPSILON:  cfg_ff.epsilon_code      <= csr_pwdata[5:0];
            default:      cfg_ff.epsilon_code      <= cfg_ff.epsilon_code;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_START:    rd_val = cfg_ff.start_symbol;
         REG_FIRST_NT: rd_val = cfg_ff.first_nonterminal;
         REG_END_MARK: rd_val = cfg_ff.end_marker_code;
         REG_EPSILON:  rd_val = cfg_ff.epsilon_code;
         default:      rd_val = 6'd0;
      endcase
   end
   assign csr_prdata = {26'd0, rd_val};

   llp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (clearing),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop)
   );

   llp_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .cfg        (cfg_ff),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire

[sim/ll1_table_driven_parser_test.sv]
`timescale 1ns / 1ps
`default_nettype none
module ll1_table_driven_parser_test;
   import llp_pkg::*;

   localparam int LIMIT_CYCLES = 2_000_000;
   localparam logic [2:0] OP_SPARE = 3'd5;   // first opcode the block does not know
   localparam logic [5:0] T_A = 6'd2, T_B = 6'd3, T_LP = 6'd4, T_RP = 6'd5, T_PLUS = 6'd6;
   localparam logic [5:0] NT_E = 6'd32, NT_ER = 6'd33, NT_T = 6'd34;

   typedef struct {
      logic [3:0] kind;
      logic [5:0] sym;
      logic [6:0] prod;
      logic [5:0] tok;
      logic       last;
   } parse_event_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   ll1_table_driven_parser i_dut (.*);

   always #4 clock = ~clock;

   // parser state mirrored by the testbench
   cfg_type     regs;
   logic [5:0]  stk [64];
   int unsigned depth;
   logic        cell_ok [32][64];
   logic [6:0]  cell_prod [32][64];
   logic [5:0]  body [128][8];
   logic [3:0]  body_len [128];
   logic [7:0]  body_written [128];
   logic        len_written [128];
   logic        follow [64][64];
   logic [1:0]  mode;
   logic [5:0]  rec_sym;

   parse_event_type event_q[$];
   logic [5:0]      sentence_q[$];
   int  fails = 0;
   int  cycles = 0;
   bit  idle_on = 1'b1;
   int  stall_left = 0;

   function automatic void add_event(logic [3:0] k, logic [5:0] s, logic [6:0] p,
                                     logic [5:0] t);
      parse_event_type e;
      e.kind = k; e.sym = s; e.prod = p; e.tok = t; e.last = 1'b0;
      event_q = {event_q, e};
   endfunction

   function automatic void parse_token(logic [5:0] tok, logic is_end);
      int n;
      logic [5:0] top;
      logic [6:0] p;
      int len;
      n = 0;
      forever begin
         if (mode == MODE_RECOVER) begin
            if (is_end || follow[rec_sym][tok]) begin
               if (depth > 0 && stk[depth-1] == rec_sym) depth--;
               mode = MODE_PARSING;
               continue;
            end
            if (n >= STEP_CAP) begin
               add_event(EV_STEP_LIM, rec_sym, 0, tok);
               mode = MODE_DONE;
               break;
            end
            add_event(EV_SKIP, rec_sym, 0, tok);
            break;
         end
         top = depth > 0 ? stk[depth-1] : regs.end_marker_code;
         if (n >= STEP_CAP) begin
            add_event(EV_STEP_LIM, top, 0, tok);
            mode = MODE_DONE;
            break;
         end
         n++;
         if (top == regs.end_marker_code || depth == 0) begin
            add_event(is_end ? EV_ACCEPT : EV_REJECT, top, 0, tok);
            mode = MODE_DONE;
            break;
         end
         if (top == regs.epsilon_code) begin
            depth--;
            add_event(EV_EPSILON, top, 0, tok);
            continue;
         end
         if (top >= regs.first_nonterminal) begin
            if (cell_ok[top[4:0]][tok]) begin
               p = cell_prod[top[4:0]][tok];
               len = body_len[p] > 8 ? 8 : body_len[p];
               if (len == 1 && body[p][0] == regs.epsilon_code) len = 0;
               if (depth - 1 + len > 64) begin
                  add_event(EV_OVERFLOW, top, p, tok);
                  mode = MODE_DONE;
                  break;
               end
               depth--;
               for (int k = len - 1; k >= 0; k--) begin
                  stk[depth] = body[p][k];
                  depth++;
               end
               add_event(EV_EXPAND, top, p, tok);
               continue;
            end
            add_event(EV_NO_RULE, top, 0, tok);
         end else begin
            if (top == tok) begin
               depth--;
               add_event(EV_MATCH, top, 0, tok);
               break;
            end
            add_event(EV_MISMATCH, top, 0, tok);
         end
         rec_sym = top;
         mode = MODE_RECOVER;
      end
      event_q[event_q.size()-1].last = 1'b1;
   endfunction

   function automatic void predict_events(cmd_type w);
      case (w.kind)
         OP_CELL: begin
            cell_ok[w.row_symbol[4:0]][w.column_symbol] = w.entry_valid;
            cell_prod[w.row_symbol[4:0]][w.column_symbol] = w.production_index;
         end
         OP_BODY: begin
            body[w.production_index][w.body_position] = w.body_symbol;
            body_len[w.production_index] = w.body_length > 8 ? 4'd8 : w.body_length;
            body_written[w.production_index][w.body_position] = 1'b1;
            len_written[w.production_index] = 1'b1;
         end
         OP_FOLLOW: follow[w.row_symbol][w.column_symbol] = w.entry_valid;
         OP_START: begin
            stk[0] = regs.end_marker_code;
            stk[1] = regs.start_symbol;
            depth = 2;
            mode = MODE_PARSING;
            rec_sym = 0;
         end
         OP_TOKEN: begin
            if (mode == MODE_PARSING || mode == MODE_RECOVER)
               parse_token(w.token_type, w.token_is_end);
            else begin
               add_event(EV_IGNORED, 0, 0, w.token_type);
               event_q[event_q.size()-1].last = 1'b1;
            end
         end
         default: begin
            add_event(EV_IGNORED, 0, 0, w.token_type);
            event_q[event_q.size()-1].last = 1'b1;
         end
      endcase
   endfunction

   // keep loads away from body entries that were never written
   function automatic void make_legal(ref cmd_type w);
      logic [7:0] wr;
      int cnt;
      int p;
      if (w.kind == OP_CELL && w.entry_valid && !len_written[w.production_index]) begin
         p = -1;
         for (int k = 0; k < 128; k++)
            if (len_written[k] && (p < 0 || $urandom_range(0, 3) == 0)) p = k;
         if (p < 0) w.entry_valid = 1'b0;
         else w.production_index = 7'(p);
      end
      if (w.kind == OP_BODY) begin
         wr = body_written[w.production_index];
         if (!wr[0] && w.body_position != 0) w.body_position = 0;
         wr[w.body_position] = 1'b1;
         cnt = 0;
         while (cnt < 8 && wr[cnt]) cnt++;
         if ((w.body_length > 8 ? 8 : w.body_length) > cnt) w.body_length = 4'(cnt);
      end
   endfunction

   function automatic cmd_type random_word();
      cmd_type w;
      w = cmd_type'($bits(cmd_type)'({$urandom, $urandom}));
      return w;
   endfunction

   task automatic send_word(cmd_type w);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= w.kind;
      req_tlast  <= w.token_is_end;
      req_tdata  <= {1'b0, w.token_type, w.entry_valid, w.body_length, w.body_symbol,
                     w.body_position, w.production_index, w.column_symbol, w.row_symbol};
      do @(posedge clock); while (!req_tready);
      predict_events(w);
   endtask

   task automatic send_load(logic [2:0] op, logic [5:0] row, logic [5:0] col,
                            logic [6:0] prod, logic [2:0] pos, logic [5:0] sym,
                            logic [3:0] len, logic valid);
      cmd_type w;
      w = random_word();
      w.kind = op; w.row_symbol = row; w.column_symbol = col; w.production_index = prod;
      w.body_position = pos; w.body_symbol = sym; w.body_length = len;
      w.entry_valid = valid;
      send_word(w);
   endtask

   task automatic send_token(logic [2:0] op, logic [5:0] tok, logic is_end);
      cmd_type w;
      w = random_word();
      w.kind = op; w.token_type = tok; w.token_is_end = is_end;
      send_word(w);
   endtask

   task automatic send_body(logic [6:0] prod, logic [5:0] s0, logic [5:0] s1,
                            logic [5:0] s2, logic [5:0] s3, int len);
      logic [5:0] syms [4];
      syms = '{s0, s1, s2, s3};
      for (int k = 0; k < len; k++)
         send_load(OP_BODY, 0, 0, prod, 3'(k), syms[k], 4'(len), 1'b0);
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (event_q.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [5:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= {26'($urandom_range(0, (1 << 26) - 1)), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_START:    regs.start_symbol = val;
         REG_FIRST_NT: regs.first_nonterminal = val;
         REG_END_MARK: regs.end_marker_code = val;
         default:      regs.epsilon_code = val;
      endcase
      csr_pwrite <= 1'b0; csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata[5:0] !== val) begin
         $error("register %0d: expected %0d, actual %0d", idx, val, csr_prdata[5:0]);
         fails++;
      end
      csr_psel <= 1'b0; csr_penable <= 1'b0;
   endtask

   task automatic set_regs(logic [5:0] st, logic [5:0] fnt, logic [5:0] em, logic [5:0] ep);
      write_reg(REG_START, st);
      write_reg(REG_FIRST_NT, fnt);
      write_reg(REG_END_MARK, em);
      write_reg(REG_EPSILON, ep);
   endtask

   // E -> T E' ; E' -> + T E' | eps ; T -> ( E ) | a | b
   task automatic load_expr_grammar();
      send_body(0, NT_T, NT_ER, 0, 0, 2);
      send_body(1, T_PLUS, NT_T, NT_ER, 0, 3);
      send_body(2, regs.epsilon_code, 0, 0, 0, 1);
      send_body(3, T_LP, NT_E, T_RP, 0, 3);
      send_body(4, T_A, 0, 0, 0, 1);
      send_body(5, T_B, 0, 0, 0, 1);
      send_load(OP_CELL, NT_E, T_A, 0, 0, 0, 0, 1'b1);
      send_load(OP_CELL, NT_E, T_B, 0, 0, 0, 0, 1'b1);
      send_load(OP_CELL, NT_E, T_LP, 0, 0, 0, 0, 1'b1);
      send_load(OP_CELL, NT_ER, T_PLUS, 1, 0, 0, 0, 1'b1);
      send_load(OP_CELL, NT_ER, T_RP, 2, 0, 0, 0, 1'b1);
      send_load(OP_CELL, NT_ER, 6'd0, 2, 0, 0, 0, 1'b1);
      send_load(OP_CELL, NT_T, T_LP, 3, 0, 0, 0, 1'b1);
      send_load(OP_CELL, NT_T, T_A, 4, 0, 0, 0, 1'b1);
      send_load(OP_CELL, NT_T, T_B, 5, 0, 0, 0, 1'b1);
      send_load(OP_FOLLOW, NT_E, T_RP, 0, 0, 0, 0, 1'b1);
      send_load(OP_FOLLOW, NT_E, 6'd0, 0, 0, 0, 0, 1'b1);
      send_load(OP_FOLLOW, NT_ER, T_RP, 0, 0, 0, 0, 1'b1);
      send_load(OP_FOLLOW, NT_T, T_PLUS, 0, 0, 0, 0, 1'b1);
      send_load(OP_FOLLOW, NT_T, T_RP, 0, 0, 0, 0, 1'b1);
      send_load(OP_FOLLOW, T_RP, T_PLUS, 0, 0, 0, 0, 1'b1);
      send_load(OP_FOLLOW, T_A, T_PLUS, 0, 0, 0, 0, 1'b1);
      wait_quiet();
   endtask

   task automatic test_ignored_words();
      send_token(OP_TOKEN, 6'd63, 1'b1);   // idle parser
      send_token(OP_SPARE, 6'd0, 1'b0);
      send_token(OP_SPARE + 3'd1, 6'd21, 1'b1);
      send_token(OP_SPARE + 3'd2, 6'd42, 1'b0);
      wait_quiet();
   endtask

   task automatic test_expr_sentences();
      // accepted: a + b
      send_token(OP_START, 0, 0);
      send_token(OP_TOKEN, T_A, 0);
      send_token(OP_TOKEN, T_PLUS, 0);
      send_token(OP_TOKEN, T_B, 0);
      send_token(OP_TOKEN, 6'd0, 1'b1);
      send_token(OP_TOKEN, T_A, 0);        // finished parse
      // no rule, skips, recovery, match, then no rule and a skip
      send_token(OP_START, 0, 0);
      send_token(OP_TOKEN, T_LP, 0);
      send_token(OP_TOKEN, T_PLUS, 0);
      send_token(OP_TOKEN, 6'd40, 0);
      send_token(OP_TOKEN, T_RP, 0);
      send_token(OP_TOKEN, T_A, 0);
      wait_quiet();
   endtask

   task automatic test_stack_overflow();
      send_body(10, NT_E, NT_E, NT_E, 0, 3);
      send_load(OP_CELL, NT_E, 6'd7, 10, 0, 0, 0, 1'b1);
      send_token(OP_START, 0, 0);
      send_token(OP_TOKEN, 6'd7, 0);
      wait_quiet();
   endtask

   task automatic test_step_limit();
      send_body(11, regs.epsilon_code, regs.epsilon_code, regs.epsilon_code, NT_E, 4);
      send_load(OP_CELL, NT_E, 6'd8, 11, 0, 0, 0, 1'b1);
      send_token(OP_START, 0, 0);
      send_token(OP_TOKEN, 6'd8, 0);
      wait_quiet();
   endtask

   function automatic void gen_expr(int lvl);
      do begin
         case ($urandom_range(0, 2))
            0: sentence_q = {sentence_q, T_A};
            1: sentence_q = {sentence_q, T_B};
            default: begin
               if (lvl < 4) begin
                  sentence_q = {sentence_q, T_LP};
                  gen_expr(lvl + 1);
                  sentence_q = {sentence_q, T_RP};
               end else sentence_q = {sentence_q, T_A};
            end
         endcase
         if ($urandom_range(0, 2) != 0) break;
         sentence_q = {sentence_q, T_PLUS};
      end while (1);
   endfunction

   task automatic run_random_mix(int words);
      cmd_type w;
      int sent;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 9) < 6) begin
            sentence_q.delete();
            gen_expr(0);
            if ($urandom_range(0, 3) == 0)
               sentence_q[$urandom_range(0, sentence_q.size() - 1)] = 6'($urandom);
            if ($urandom_range(0, 5) == 0 && sentence_q.size() > 1)
               sentence_q.delete($urandom_range(0, sentence_q.size() - 1));
            send_token(OP_START, 0, 0);
            sent++;
            foreach (sentence_q[k]) begin
               send_token(OP_TOKEN, sentence_q[k], 1'b0);
               sent++;
            end
            if ($urandom_range(0, 5) != 0) begin
               send_token(OP_TOKEN, $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'd0, 1'b1);
               sent++;
            end
         end else begin
            w = random_word();
            case ($urandom_range(0, 9))
               0, 1: w.kind = OP_CELL;
               2, 3: w.kind = OP_BODY;
               4:    w.kind = OP_FOLLOW;
               5:    w.kind = OP_START;
               6, 7: w.kind = OP_TOKEN;
               default: w.kind = 3'($urandom_range(OP_SPARE, 7));
            endcase
            make_legal(w);
            send_word(w);
            sent++;
         end
      end
      wait_quiet();
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (event_q.size() == 0) begin
            $error("unexpected word: kind %0d", rsp_tuser);
            fails++;
         end else begin
            parse_event_type e;
            e = event_q.pop_front();
            if (rsp_tuser !== e.kind) begin
               $error("event_kind: expected %0d, actual %0d", e.kind, rsp_tuser); fails++;
            end
            if (rsp_tdata[5:0] !== e.sym) begin
               $error("event_symbol: expected %0d, actual %0d", e.sym, rsp_tdata[5:0]);
               fails++;
            end
            if (rsp_tdata[12:6] !== e.prod) begin
               $error("event_production: expected %0d, actual %0d", e.prod,
                      rsp_tdata[12:6]);
               fails++;
            end
            if (rsp_tdata[18:13] !== e.tok) begin
               $error("event_token: expected %0d, actual %0d", e.tok, rsp_tdata[18:13]);
               fails++;
            end
            if (rsp_tlast !== e.last) begin
               $error("last_event: expected %0d, actual %0d", e.last, rsp_tlast); fails++;
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("ll1_table_driven_parser test failed");
         $finish;
      end
   end

   initial begin
      regs = '{start_symbol: 6'd32, first_nonterminal: 6'd32, end_marker_code: 6'd0,
               epsilon_code: 6'd1};
      depth = 0; mode = MODE_IDLE; rec_sym = 0;
      for (int r = 0; r < 32; r++)
         for (int c = 0; c < 64; c++) begin
            cell_ok[r][c] = 1'b0; cell_prod[r][c] = '0;
         end
      for (int r = 0; r < 64; r++)
         for (int c = 0; c < 64; c++) follow[r][c] = 1'b0;
      for (int p = 0; p < 128; p++) begin
         body_written[p] = '0; len_written[p] = 1'b0; body_len[p] = '0;
         for (int k = 0; k < 8; k++) body[p][k] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_ignored_words();
      load_expr_grammar();
      test_expr_sentences();
      test_stack_overflow();
      test_step_limit();
      run_random_mix(80);
      set_regs(6'd0, 6'd1, 6'd63, 6'd63);
      run_random_mix(40);
      set_regs(6'd63, 6'd63, 6'd0, 6'd0);
      run_random_mix(40);
      set_regs(6'd32, 6'd32, 6'd0, 6'd1);
      idle_on = 1'b0;
      run_random_mix(50);
      wait_quiet();
      if (fails == 0) $display("ll1_table_driven_parser test passed");
      else $display("ll1_table_driven_parser test failed");
      $finish;
   end

endmodule
`default_nettype wire
